/* rtl/assert_macros.svh */
// Assertion macros shared by the IR pulse-width frame decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* rtl/irpw_pkg.sv */
// Shared types and constants for the IR pulse-width frame decoder.
// No dependencies; used by the front end, back end and top level.
package irpw_pkg;

    // Field widths
    localparam int TIME_W  = 14;
    localparam int CODE_W  = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 3;

    // Queue depths
    localparam int TOK_FIFO_DEPTH = 4;
    localparam int RES_FIFO_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MAX = 3'd5;

    // Frame machine phases
    localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BIT0 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BIT1 = 2'd2;
    localparam logic [PHASE_W-1:0] PH_PAR  = 2'd3;

    // Classified logic pulse handed from front end to back end
    typedef struct packed {
        logic marker;   // header marker precedes this pulse
        logic bit_val;  // 0 = logic zero window, 1 = logic one window
        logic head;     // interval also lies in the header window
    } token_t;

    // Decoded frame
    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              parity_error;
    } result_t;

endpackage

/* rtl/irpw_fifo.sv */
// Small generic register queue with push/full and pop/empty sides.
// No package dependency; includes assert_macros.svh.
`include "assert_macros.svh"

module irpw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > DEPTH_CNT, "queue count over depth")
    `ASSERT_AT(a_count_step, clk, rst_n, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not advance on push")

endmodule

/* rtl/irpw_front.sv */
// Front end: window registers, interval computation and pulse classification.
// Depends on irpw_pkg; includes assert_macros.svh.
`include "assert_macros.svh"

module irpw_front #(
    parameter int TIME_WRAP_US = 10000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [irpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irpw_pkg::TIME_W-1:0]         cfg_data,
    input  logic                                push,
    input  logic [irpw_pkg::TIME_W-1:0]         edge_time_us,
    input  logic                                tok_full,
    output logic                                tok_push,
    output irpw_pkg::token_t                    tok_data
);

    localparam int TW = irpw_pkg::TIME_W;
    localparam logic [TW:0] WRAP_W = (TW + 1)'(TIME_WRAP_US);

    logic [TW-1:0] zero_min_reg, zero_max_reg;
    logic [TW-1:0] one_min_reg, one_max_reg;
    logic [TW-1:0] head_min_reg, head_max_reg;
    logic [TW-1:0] last_edge_reg, last_edge_next;
    logic          armed_reg, armed_next;

    logic          accept;
    logic [TW:0]   wrapped_sum;
    logic [TW-1:0] ival;
    logic          ival_ok;
    logic          is_zero, is_one, is_head, is_logic;

    function automatic logic in_win(input logic [TW-1:0] v, input logic [TW-1:0] lo,
                                    input logic [TW-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    assign accept = push && !tok_full;

    // Interval since last edge, wrapping once at TIME_WRAP_US
    always_comb
    begin
        wrapped_sum = {1'b0, edge_time_us} + WRAP_W;
        if (edge_time_us >= last_edge_reg)
        begin
            ival    = edge_time_us - last_edge_reg;
            ival_ok = 1'b1;
        end
        else
        begin
            ival    = TW'(wrapped_sum - {1'b0, last_edge_reg});
            ival_ok = (wrapped_sum >= {1'b0, last_edge_reg});
        end
    end

    // Window tests; zero wins over one
    assign is_zero  = ival_ok && in_win(ival, zero_min_reg, zero_max_reg);
    assign is_one   = ival_ok && in_win(ival, one_min_reg, one_max_reg);
    assign is_head  = ival_ok && in_win(ival, head_min_reg, head_max_reg);
    assign is_logic = is_zero || is_one;

    assign tok_push         = accept && is_logic;
    assign tok_data.marker  = armed_reg;
    assign tok_data.bit_val = !is_zero;
    assign tok_data.head    = is_head;

    // Header arming and last edge tracking
    always_comb
    begin
        last_edge_next = last_edge_reg;
        armed_next     = armed_reg;
        if (accept)
        begin
            last_edge_next = edge_time_us;
            if (is_logic)
            begin
                armed_next = 1'b0;
            end
            else
            begin
                armed_next = is_head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            last_edge_reg <= last_edge_next;
            armed_reg     <= armed_next;
        end
    end

    // Window configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_min_reg <= '0;
            zero_max_reg <= '0;
            one_min_reg  <= '0;
            one_max_reg  <= '0;
            head_min_reg <= '0;
            head_max_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                irpw_pkg::CFG_ZERO_MIN: zero_min_reg <= cfg_data;
                irpw_pkg::CFG_ZERO_MAX: zero_max_reg <= cfg_data;
                irpw_pkg::CFG_ONE_MIN:  one_min_reg  <= cfg_data;
                irpw_pkg::CFG_ONE_MAX:  one_max_reg  <= cfg_data;
                irpw_pkg::CFG_HEAD_MIN: head_min_reg <= cfg_data;
                irpw_pkg::CFG_HEAD_MAX: head_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_push_full, clk, rst_n, tok_push && tok_full, "token pushed into full queue")
    `ASSERT_AT(a_marker_clears, clk, rst_n, tok_push |=> !armed_reg, "header flag left armed after logic pulse")

endmodule

/* rtl/irpw_back.sv */
// Back end: frame machine that assembles data bits and checks even parity.
// Depends on irpw_pkg; includes assert_macros.svh.
`include "assert_macros.svh"

module irpw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_empty,
    input  irpw_pkg::token_t     tok_data,
    output logic                 tok_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output irpw_pkg::result_t    res_data
);

    logic [irpw_pkg::PHASE_W-1:0] phase_reg, phase_next, phase_mid;
    logic [irpw_pkg::CODE_W-1:0]  code_reg, code_next;

    // Take a token only when a result slot is free
    assign tok_pop = !tok_empty && !res_full;

    assign res_data.key_code     = code_reg;
    assign res_data.parity_error = (code_reg[0] ^ code_reg[1]) != tok_data.bit_val;

    // Header marker first, then the logic pulse itself
    always_comb
    begin
        phase_mid  = phase_reg;
        phase_next = phase_reg;
        code_next  = code_reg;
        res_push   = 1'b0;
        if (tok_data.marker)
        begin
            phase_mid = (phase_reg == irpw_pkg::PH_WAIT) ? irpw_pkg::PH_BIT0
                                                         : irpw_pkg::PH_WAIT;
        end
        if (tok_pop)
        begin
            case (phase_mid)
                irpw_pkg::PH_WAIT:
                begin
                    phase_next = tok_data.head ? irpw_pkg::PH_BIT0 : irpw_pkg::PH_WAIT;
                end
                irpw_pkg::PH_BIT0:
                begin
                    code_next[0] = tok_data.bit_val;
                    phase_next   = irpw_pkg::PH_BIT1;
                end
                irpw_pkg::PH_BIT1:
                begin
                    code_next[1] = tok_data.bit_val;
                    phase_next   = irpw_pkg::PH_PAR;
                end
                irpw_pkg::PH_PAR:
                begin
                    phase_next = irpw_pkg::PH_WAIT;
                    res_push   = 1'b1;
                end
                default:
                begin
                    phase_next = irpw_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= irpw_pkg::PH_WAIT;
            code_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
        end
    end

    `ASSERT_NEVER(a_res_from_par, clk, rst_n, res_push && (phase_reg != irpw_pkg::PH_PAR), "result outside parity phase")
    `ASSERT_AT(a_bit1_follows, clk, rst_n, (tok_pop && !tok_data.marker && (phase_reg == irpw_pkg::PH_BIT0)) |=> (phase_reg == irpw_pkg::PH_BIT1), "data bit 0 did not advance frame")

endmodule

/* rtl/ir_pulse_width_frame_decoder_unit.sv */
// A frame result is visible (empty low) once the frame machine has taken its parity token
// from the token queue and pushed the result into the result queue.
// Throughput: one edge per cycle unless full, classified in the accept cycle; back end runs
// the frame machine one token per cycle from a four-entry token queue unless res_full.
// Reset clears windows, last edge time, header flag, frame phase, code and both queues.
// Top level: front end, token queue, frame back end and result queue.
// Depends on irpw_pkg, irpw_front, irpw_fifo and irpw_back.
module ir_pulse_width_frame_decoder_unit #(
    parameter int TIME_WRAP_US = 10000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [irpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpw_pkg::TIME_W-1:0]       cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [irpw_pkg::TIME_W-1:0]       edge_time_us,
    input  logic                              pop,
    output logic                              empty,
    output logic [irpw_pkg::CODE_W-1:0]       key_code,
    output logic                              parity_error
);

    localparam int TOK_W = $bits(irpw_pkg::token_t);
    localparam int RES_W = $bits(irpw_pkg::result_t);

    irpw_pkg::token_t  tok_in, tok_out;
    irpw_pkg::result_t res_in, res_out;
    logic              tok_push, tok_full, tok_pop, tok_empty;
    logic              res_push, res_full;

    // Classification stage
    irpw_front #(
        .TIME_WRAP_US(TIME_WRAP_US)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .edge_time_us(edge_time_us),
        .tok_full    (tok_full),
        .tok_push    (tok_push),
        .tok_data    (tok_in)
    );

    assign full = tok_full;

    // Token queue between front and back
    irpw_fifo #(
        .WIDTH(TOK_W),
        .DEPTH(irpw_pkg::TOK_FIFO_DEPTH)
    ) u_tok_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (tok_push),
        .wr_data(tok_in),
        .full   (tok_full),
        .pop    (tok_pop),
        .rd_data(tok_out),
        .empty  (tok_empty)
    );

    // Frame machine
    irpw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_empty(tok_empty),
        .tok_data (tok_out),
        .tok_pop  (tok_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    // Result queue toward the consumer
    irpw_fifo #(
        .WIDTH(RES_W),
        .DEPTH(irpw_pkg::RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .pop    (pop),
        .rd_data(res_out),
        .empty  (empty)
    );

    assign key_code     = res_out.key_code;
    assign parity_error = res_out.parity_error;

endmodule
